// ===== src/sufe_pkg.sv =====
`timescale 1ns / 1ps
package sufe_pkg;
   localparam int NodeBits = 16;
   localparam int MaxNodes = 1 << NodeBits;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_CONNECT = 2'd1,
      OP_QUERY   = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] source_start;
      logic [15:0] dest_start;
      logic [15:0] pair_count;
      logic [15:0] dest_stride;
      logic [15:0] source_stride;
   } req_type;

   typedef struct packed {
      logic [15:0] joined_pairs;
      logic [15:0] separate_pairs;
   } rsp_type;

   typedef enum logic [3:0] {
      DP_IDLE    = 4'd0,
      DP_LOAD    = 4'd1,
      DP_RDADDR  = 4'd2,
      DP_FOLLOW  = 4'd3,
      DP_SETCUR  = 4'd4,
      DP_COMPRESS= 4'd5,
      DP_SAVERS  = 4'd6,
      DP_SAVERD  = 4'd7,
      DP_PAIR    = 4'd8,
      DP_CLEAR   = 4'd9,
      DP_USEDST  = 4'd10
   } dp_cmd_type;

   typedef struct packed {
      logic root_found;
      logic path_done;
      logic last_pair;
      logic clear_done;
   } dp_status_type;
endpackage

// ===== src/sufe_datapath.sv =====
`timescale 1ns / 1ps
module sufe_datapath
   import sufe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  req_type       req,
   input  logic [15:0]   node_count,
   output dp_status_type status,
   output rsp_type       result
);
   logic [NodeBits-1:0] mem [MaxNodes];
   logic [NodeBits-1:0] rdata_ff;
   logic                wen;
   logic [NodeBits-1:0] waddr, wdata, raddr;
   logic [NodeBits-1:0] r_ff, cur_ff, addr_ff, rs_ff, rd_ff;
   logic [15:0]         src_ff, dst_ff, cnt_ff, ss_ff, ds_ff, join_ff, sep_ff;
   logic                query_ff;
   logic [16:0]         src_sum, dst_sum;
   logic [NodeBits:0]   clr_ff;
   logic [15:0]         join_sum, sep_sum;
   rsp_type             out_ff;

   assign src_sum = {1'b0, src_ff} + {1'b0, ss_ff};
   assign dst_sum = {1'b0, dst_ff} + {1'b0, ds_ff};
   assign join_sum = join_ff + {15'd0, rs_ff == rd_ff};
   assign sep_sum = sep_ff + {15'd0, rs_ff != rd_ff};

   always_comb begin
      wen = 1'b0;
      waddr = cur_ff;
      wdata = r_ff;
      raddr = addr_ff;
      case (cmd)
         DP_COMPRESS: begin
            wen = (rdata_ff != cur_ff);
            raddr = rdata_ff;
         end
         DP_CLEAR: begin
            wen = 1'b1;
            waddr = clr_ff[NodeBits-1:0];
            wdata = clr_ff[NodeBits-1:0];
         end
         DP_PAIR: begin
            wen = !query_ff && (rs_ff != rd_ff);
            waddr = rs_ff;
            wdata = rd_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wen) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd == DP_CLEAR) begin
         clr_ff <= clr_ff + 1'b1;
      end else if (cmd == DP_LOAD) begin
         clr_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == DP_PAIR && query_ff && cnt_ff == 16'd1) begin
         out_ff.joined_pairs <= join_sum;
         out_ff.separate_pairs <= sep_sum;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         DP_LOAD: begin
            src_ff <= req.source_start;
            dst_ff <= req.dest_start;
            cnt_ff <= (req.pair_count == '0) ? 16'd1 : req.pair_count;
            ds_ff <= (req.dest_stride == '0) ? 16'd1 : req.dest_stride;
            ss_ff <= req.source_stride;
            query_ff <= (req.opcode == OP_QUERY);
            join_ff <= '0;
            sep_ff <= '0;
            addr_ff <= req.source_start;
         end
         DP_RDADDR: begin
            r_ff <= addr_ff;
            cur_ff <= addr_ff;
         end
         DP_FOLLOW: begin
            r_ff <= rdata_ff;
            addr_ff <= rdata_ff;
         end
         DP_SETCUR: addr_ff <= cur_ff;
         DP_COMPRESS: begin
            cur_ff <= rdata_ff;
            addr_ff <= rdata_ff;
         end
         DP_SAVERS: begin
            rs_ff <= r_ff;
            addr_ff <= dst_ff;
         end
         DP_SAVERD: rd_ff <= r_ff;
         DP_PAIR: begin
            if (query_ff) begin
               join_ff <= join_sum;
               sep_ff <= sep_sum;
            end
            if (src_sum <= {1'b0, node_count}) src_ff <= src_sum[15:0];
            if (dst_sum <= {1'b0, node_count}) dst_ff <= dst_sum[15:0];
            addr_ff <= (src_sum <= {1'b0, node_count}) ? src_sum[15:0] : src_ff;
            cnt_ff <= cnt_ff - 1'b1;
         end
         default: ;
      endcase
   end

   assign status.root_found = (rdata_ff == r_ff);
   assign status.path_done  = (rdata_ff == cur_ff);
   assign status.last_pair  = (cnt_ff == 16'd1);
   assign status.clear_done = clr_ff[NodeBits];
   assign result = out_ff;
endmodule

// ===== src/sufe_control.sv =====
`timescale 1ns / 1ps
module sufe_control
   import sufe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_opcode,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);
   typedef enum logic [10:0] {
      S_INIT  = 11'b00000000001,
      S_IDLE  = 11'b00000000010,
      S_RD    = 11'b00000000100,
      S_WALK  = 11'b00000001000,
      S_FOUND = 11'b00000010000,
      S_CRD   = 11'b00000100000,
      S_COMP  = 11'b00001000000,
      S_NEXT  = 11'b00010000000,
      S_PAIR  = 11'b00100000000,
      S_CLEAR = 11'b01000000000,
      S_WAIT  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic      second_ff, second_in, rsp_ff, rsp_in, query_ff, query_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_ff;

   always_comb begin
      state_in = state_ff;
      second_in = second_ff;
      query_in = query_ff;
      rsp_in = rsp_ff && !rsp_ready;
      cmd = DP_IDLE;
      case (state_ff)
         S_INIT: begin
            cmd = DP_CLEAR;
            if (status.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd = DP_LOAD;
               query_in = (req_opcode == OP_QUERY);
               second_in = 1'b0;
               case (req_opcode)
                  OP_CLEAR: state_in = S_CLEAR;
                  OP_CONNECT, OP_QUERY: state_in = S_RD;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAR: begin
            cmd = DP_CLEAR;
            if (status.clear_done) state_in = S_IDLE;
         end
         S_RD: begin
            cmd = DP_RDADDR;
            state_in = S_WAIT;
         end
         S_WAIT: state_in = S_WALK;
         S_WALK: begin
            if (status.root_found) begin
               cmd = DP_SETCUR;
               state_in = S_FOUND;
            end else begin
               cmd = DP_FOLLOW;
               state_in = S_WAIT;
            end
         end
         S_FOUND: state_in = S_CRD;
         S_CRD: state_in = S_COMP;
         S_COMP: begin
            if (status.path_done) begin
               state_in = S_NEXT;
            end else begin
               cmd = DP_COMPRESS;
               state_in = S_CRD;
            end
         end
         S_NEXT: begin
            if (!second_ff) begin
               cmd = DP_SAVERS;
               second_in = 1'b1;
               state_in = S_RD;
            end else begin
               cmd = DP_SAVERD;
               state_in = S_PAIR;
            end
         end
         S_PAIR: begin
            if (!(status.last_pair && query_ff && rsp_ff && !rsp_ready)) begin
               cmd = DP_PAIR;
               second_in = 1'b0;
               if (status.last_pair) begin
                  state_in = S_IDLE;
                  if (query_ff) rsp_in = 1'b1;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         second_ff <= 1'b0;
         rsp_ff <= 1'b0;
         query_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         second_ff <= second_in;
         rsp_ff <= rsp_in;
         query_ff <= query_in;
      end
   end
endmodule

// ===== src/strided_union_find_engine_unit.sv =====
`timescale 1ns / 1ps
// Union-find engine over a 65536-entry parent memory with full path compression.
// After reset a clearing pass runs over every entry before the first item is taken,
// and a clear item repeats that pass once it is accepted. Each connect or query
// pair costs two find walks, each following links to the root and then compressing
// the path, plus one step to link or count the pair, all through the single parent
// memory; a run handles pair_count pairs once it is accepted. A query
// returns one result from an output register, held until taken; the next item is
// accepted meanwhile, and a query that ends while an earlier result still waits
// holds in its last pair until that result is taken.
module strided_union_find_engine_unit
   import sufe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   dp_cmd_type    cmd;
   dp_status_type status;
   logic [15:0]   node_count_ff;

   always_ff @(posedge clock) begin
      if (reset) node_count_ff <= 16'hFFFF;
      else if (csr_write_enable) node_count_ff <= csr_write_data;
   end

   sufe_control u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_data.opcode), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .status(status), .cmd(cmd)
   );

   sufe_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .req(req_data),
      .node_count(node_count_ff), .status(status), .result(rsp_data)
   );
endmodule

// ===== src/sufe_checker.sv =====
`timescale 1ns / 1ps
module sufe_checker
   import sufe_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({rsp_valid, req_ready})) else $error("unknown handshake");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.opcode != OP_NONE |=> !req_ready)
      else $error("ready after transfer");
endmodule

bind strided_union_find_engine_unit sufe_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
